FILE: src/xmcrc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the XModem-CRC receiver.
`timescale 1ns / 1ps

package xmcrc_pkg;

    // Start and control bytes
    localparam logic [7:0] SOH = 8'h01;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] EOT = 8'h04;

    // Receive phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_NUM   = 3'd1;
    localparam logic [2:0] PH_INV   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRCH  = 3'd4;
    localparam logic [2:0] PH_CRCL  = 3'd5;

    // Frame status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TO_START  = 4'd1;
    localparam logic [3:0] ST_TO_HEADER = 4'd2;
    localparam logic [3:0] ST_TO_DATA   = 4'd3;
    localparam logic [3:0] ST_TO_CRC    = 4'd4;
    localparam logic [3:0] ST_CANCEL    = 4'd5;
    localparam logic [3:0] ST_CRC_ERR   = 4'd6;
    localparam logic [3:0] ST_EOF       = 4'd7;
    localparam logic [3:0] ST_UNKNOWN   = 4'd8;

    localparam logic [10:0] LEN_SMALL = 11'd128;
    localparam logic [10:0] LEN_LARGE = 11'd1024;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // One received word: a byte or a timeout event
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timed_out;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic        frame_done;
        logic [3:0]  status;
        logic [10:0] frame_length;
        logic        send_cancel;
    } t_result;

    // CRC-16 (poly 0x1021) update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/xmcrc_in_stage.sv
// Input register stage: captures one received word per accepted handshake.
`timescale 1ns / 1ps

module xmcrc_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  xmcrc_pkg::t_in_word i_word,
    input  logic               i_take,
    output logic               o_valid,
    output xmcrc_pkg::t_in_word o_word
);
    import xmcrc_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     w_accept;

    // Accept when empty or when the held word moves on this cycle
    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: src/xmcrc_frame_fsm.sv
// Frame state machine with CRC update and the result register.
`timescale 1ns / 1ps

module xmcrc_frame_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  xmcrc_pkg::t_in_word i_word,
    input  logic [7:0]          i_expected,
    output logic                o_take,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output xmcrc_pkg::t_result  o_result
);
    import xmcrc_pkg::*;

    logic [2:0]  r_phase,  n_phase;
    logic        r_large,  n_large;
    logic [10:0] r_count,  n_count;
    logic [7:0]  r_number, n_number;
    logic        r_bad,    n_bad;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic        r_out_valid;
    t_result     r_result;

    logic        w_has;
    t_result     w_res;
    logic [10:0] w_len;
    logic [10:0] w_count_inc;

    // Move a word on when the result slot is free or draining
    assign o_take = i_valid && (!r_out_valid || i_out_ready);

    assign w_len       = r_large ? LEN_LARGE : LEN_SMALL;
    assign w_count_inc = r_count + 11'd1;

    // Next state and result for the held word
    always_comb begin
        n_phase  = r_phase;
        n_large  = r_large;
        n_count  = r_count;
        n_number = r_number;
        n_bad    = r_bad;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        w_has    = 1'b0;
        w_res    = '0;
        w_res.frame_done = 1'b1;
        case (r_phase)
            PH_NUM, PH_INV: begin
                if (i_word.timed_out) begin
                    w_has = 1'b1;
                    w_res.status = ST_TO_HEADER;
                    n_phase = PH_START;
                end else if (r_phase == PH_NUM) begin
                    n_number = i_word.rx_byte;
                    n_phase  = PH_INV;
                end else begin
                    n_bad   = (r_number != i_expected) || (r_number != ~i_word.rx_byte);
                    n_crc   = '0;
                    n_count = '0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                w_has = 1'b1;
                if (i_word.timed_out) begin
                    w_res.status = ST_TO_DATA;
                    n_phase = PH_START;
                end else begin
                    n_crc   = crc_byte(r_crc, i_word.rx_byte);
                    n_count = w_count_inc;
                    if (w_count_inc >= w_len) begin
                        n_phase = PH_CRCH;
                    end
                    w_res.data_byte  = i_word.rx_byte;
                    w_res.is_payload = 1'b1;
                    w_res.frame_done = 1'b0;
                end
            end
            PH_CRCH: begin
                if (i_word.timed_out) begin
                    w_has = 1'b1;
                    w_res.status = ST_TO_CRC;
                    n_phase = PH_START;
                end else begin
                    n_crc_hi = i_word.rx_byte;
                    n_phase  = PH_CRCL;
                end
            end
            PH_CRCL: begin
                w_has   = 1'b1;
                n_phase = PH_START;
                if (i_word.timed_out) begin
                    w_res.status = ST_TO_CRC;
                end else if (r_bad) begin
                    w_res.status      = ST_CANCEL;
                    w_res.send_cancel = 1'b1;
                end else if ({r_crc_hi, i_word.rx_byte} != r_crc) begin
                    w_res.status = ST_CRC_ERR;
                end else begin
                    w_res.status       = ST_OK;
                    w_res.frame_length = w_len;
                end
            end
            default: begin
                // Waiting for a start byte; unused codes land here too
                n_phase = PH_START;
                if (i_word.timed_out) begin
                    w_has = 1'b1;
                    w_res.status = ST_TO_START;
                end else if (i_word.rx_byte == SOH || i_word.rx_byte == STX) begin
                    n_large = (i_word.rx_byte == STX);
                    n_phase = PH_NUM;
                end else if (i_word.rx_byte == EOT) begin
                    w_has = 1'b1;
                    w_res.status = ST_EOF;
                end else begin
                    w_has = 1'b1;
                    w_res.status    = ST_UNKNOWN;
                    w_res.data_byte = i_word.rx_byte;
                end
            end
        endcase
    end

    // Advance frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_large  <= 1'b0;
            r_count  <= '0;
            r_number <= '0;
            r_bad    <= 1'b0;
            r_crc    <= '0;
            r_crc_hi <= '0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_large  <= n_large;
            r_count  <= n_count;
            r_number <= n_number;
            r_bad    <= n_bad;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= w_has;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (o_take && w_has) begin
            r_result <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: src/xmodem_crc_frame_receiver_core.sv
// Top level of the XModem-CRC frame receiver.
`timescale 1ns / 1ps
// Usage:
//   Slave stream: one word per received event. tdata carries the byte,
//   tuser set means the awaited byte timed out (tdata is then ignored).
//   Master stream: one word per payload byte (tuser set) and one status
//   word at the end of each frame run (tlast set). tdata carries, from bit 0:
//   data byte, status, frame length, send-cancel request.
//   Config channel: writes the expected block number (reset value 1); write it
//   only while no frame is in progress and the pipeline is empty.
// Path: a word is registered in the input register, then in the result
//   register. Throughput: one word per cycle while m_axis_tready is held high,
//   set by the single-pass state update with an unrolled eight-bit CRC step.
// Reset: synchronous, active low; the receiver returns to waiting for a start
//   byte and both pipeline registers empty.
// Stall: when the master side holds tready low, the held result waits, one
//   more word is held in the input register, then s_axis_tready drops.

module xmodem_crc_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] timed_out
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [11:8] status,
                                        // [22:12] frame_length, [23] send_cancel
    output logic        m_axis_tuser,   // [0] is_payload
    output logic        m_axis_tlast,   // frame_done
    // Expected block number
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import xmcrc_pkg::*;

    logic [7:0] r_expected_frame;
    t_in_word   w_in_word;
    t_in_word   w_held_word;
    logic       w_held_valid;
    logic       w_take;
    t_result    w_result;

    // Store the expected block number
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_frame <= 8'd1;
        end else if (i_cfg_valid) begin
            r_expected_frame <= i_cfg_data;
        end
    end

    assign w_in_word.rx_byte   = s_axis_tdata;
    assign w_in_word.timed_out = s_axis_tuser;

    xmcrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_word  (w_in_word),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_word  (w_held_word)
    );

    xmcrc_frame_fsm u_frame_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_held_valid),
        .i_word      (w_held_word),
        .i_expected  (r_expected_frame),
        .o_take      (w_take),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    // Pack the result word
    assign m_axis_tdata = {w_result.send_cancel, w_result.frame_length,
                           w_result.status, w_result.data_byte};
    assign m_axis_tuser = w_result.is_payload;
    assign m_axis_tlast = w_result.frame_done;

endmodule
